/* hw/rtl/hsfc_pkg.sv */
// Shared mode type and helper functions for the half/single converter.
package hsfc_pkg;

  typedef enum logic {
    MODE_H2S = 1'b0,
    MODE_S2H = 1'b1
  } mode_e;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic       sgn;
    logic [4:0] ex;
    logic [9:0] fr;
    logic [3:0] n;
    logic [9:0] nf;
    logic [7:0] sex;
    begin
      sgn = h[15];
      ex  = h[14:10];
      fr  = h[9:0];
      n   = 4'd0;
      nf  = 10'd0;
      sex = 8'd0;
      if (ex == 5'd0) begin
        if (fr == 10'd0) begin
          half_to_single = {sgn, 31'd0};
        end else begin
          for (int i = 9; i >= 0; i--) begin
            if (fr[i] && n == 4'd0 && nf == 10'd0) begin
              n  = 4'(9 - i);
              nf = fr << (10 - i);
            end
          end
          sex = 8'd112 - {4'd0, n};
          half_to_single = {sgn, sex, nf, 13'd0};
        end
      end else if (ex == 5'h1F) begin
        half_to_single = {sgn, 8'hFF, fr, 13'd0};
      end else begin
        sex = {3'd0, ex} + 8'd112;
        half_to_single = {sgn, sex, fr, 13'd0};
      end
    end
  endfunction

  function automatic logic [15:0] single_to_half(input logic [31:0] s);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] fr;
    logic [9:0]  m;
    logic [7:0]  sh;
    begin
      sgn = s[31];
      ex  = s[30:23];
      fr  = s[22:0];
      m   = {1'b1, fr[22:14]};
      sh  = 8'd112 - ex;
      if (ex == 8'd0) begin
        single_to_half = {sgn, 15'd0};
      end else if (ex == 8'hFF) begin
        single_to_half = {sgn, 5'h1F, (fr != 23'd0), 9'd0};
      end else if (ex >= 8'd143) begin
        single_to_half = {sgn, 5'h1F, 10'd0};
      end else if (ex <= 8'd112) begin
        single_to_half = {sgn, 5'd0, (sh >= 8'd11) ? 10'd0 : (m >> sh[3:0])};
      end else begin
        sh = ex - 8'd112;
        single_to_half = {sgn, sh[4:0], fr[22:13]};
      end
    end
  endfunction

endpackage

/* hw/rtl/hsfc_core.sv */
// Combinational conversion datapath for both directions.
module hsfc_core (
  input  hsfc_pkg::mode_e mode_i,
  input  logic [31:0]     value_i,
  output logic [31:0]     value_o
);
  import hsfc_pkg::*;

  always_comb begin
    if (mode_i == MODE_H2S) begin
      value_o = half_to_single(value_i[15:0]);
    end else begin
      value_o = {16'd0, single_to_half(value_i)};
    end
  end

endmodule

/* hw/rtl/half_single_float_convert.sv */
// Top level of the half/single float converter.
// The start word passes the input register and then the result register; done rises with the result.
// The receiver samples the result word while done is high.
// Throughput: one word per cycle; busy is always low.
// The path is an input register, the conversion logic and a result register.
// Reset clears the valid flags; data registers are not reset.
// The receiver cannot stall, so no result is ever held back.
module half_single_float_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [31:0] value_in_i,
  output logic        done,
  output logic [31:0] value_out_o
);
  import hsfc_pkg::*;

  logic        in_vld_q;
  logic        out_vld_q;
  mode_e       mode_q;
  logic [31:0] val_q;
  logic [31:0] res_d;
  logic [31:0] res_q;

  assign busy = 1'b0;

  hsfc_core u_core (
    .mode_i  (mode_q),
    .value_i (val_q),
    .value_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      mode_q <= mode_e'(mode_i);
      val_q  <= value_in_i;
    end
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done        = out_vld_q;
  assign value_out_o = res_q;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start, 2) && $past(rst_ni, 2) |-> done)
    else $error("result word missing");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(in_vld_q))
    else $error("result word without input");
  a_half_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && mode_q == MODE_S2H |=> res_q[31:16] == 16'd0)
    else $error("narrowed word has upper bits set");

endmodule

/* test/tb_top.sv */
// Testbench for the half/single float converter with a scoreboard predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hsfc_pkg::*;

  int unsigned n_errors = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    n_errors++;
  endtask

  class convert_scoreboard;
    logic [31:0] pending_words[$];

    function automatic logic [31:0] widen_half(logic [15:0] h);
      logic [31:0] sgn;
      logic [4:0] ex;
      logic [9:0] fr;
      int unsigned n;
      sgn = {h[15], 31'd0};
      ex = h[14:10];
      fr = h[9:0];
      n = 0;
      if (ex == 5'd0) begin
        if (fr == 10'd0) return sgn;
        while (!fr[9] && n < 10) begin
          fr = fr << 1;
          n++;
        end
        fr = fr << 1;
        return sgn | (32'(112 - n) << 23) | (32'(fr) << 13);
      end
      if (ex == 5'h1F) return sgn | (32'hFF << 23) | (32'(fr) << 13);
      return sgn | ((32'(ex) + 32'd112) << 23) | (32'(fr) << 13);
    endfunction

    function automatic logic [31:0] narrow_single(logic [31:0] s);
      logic [31:0] sgn;
      int re;
      int unsigned sh;
      logic [31:0] m;
      sgn = {16'd0, s[31], 15'd0};
      if (s[30:23] == 8'd0) return sgn;
      if (s[30:23] == 8'hFF) return sgn | 32'h7C00 | ((s[22:0] != 0) ? 32'h200 : 32'h0);
      re = int'(s[30:23]) - 112;
      if (re >= 31) return sgn | 32'h7C00;
      if (re <= 0) begin
        sh = -re;
        m = 32'h200 | 32'(s[22:14]);
        m = (sh >= 11) ? 32'd0 : (m >> sh);
        return sgn | m;
      end
      return sgn | (32'(re) << 10) | 32'(s[22:13]);
    endfunction

    function void note_word(mode_e mode, logic [31:0] v);
      if (mode == MODE_H2S) pending_words.push_back(widen_half(v[15:0]));
      else pending_words.push_back(narrow_single(v));
    endfunction

    task check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      want = pending_words.pop_front();
      if (got !== want) report_mismatch($sformatf("value_out %h, want %h", got, want));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic mode_i = 1'b0;
  logic [31:0] value_in_i = '0;
  logic busy;
  logic done;
  logic [31:0] value_out_o;
  int unsigned idle_pct = 0;
  convert_scoreboard sb = new();

  half_single_float_convert i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .mode_i(mode_i), .value_in_i(value_in_i), .done(done), .value_out_o(value_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done) sb.check_result(value_out_o);
  end

  // Holds start until the word is taken; idle gaps come before the word.
  task automatic send_word(input mode_e mode, input logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    mode_i <= mode;
    value_in_i <= v;
    do @(posedge clk_i); while (busy);
    sb.note_word(mode, v);
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    while (sb.pending_words.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_single();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(5))
      0: v[30:23] = 8'($urandom_range(100, 113));
      1: v[30:23] = 8'($urandom_range(113, 142));
      2: v[30:23] = 8'($urandom_range(142, 144));
      3: v[30:23] = ($urandom_range(1)) ? 8'd0 : 8'hFF;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] random_half();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(3))
      0: v[14:10] = 5'd0;
      1: v[14:10] = 5'h1F;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] directed_h[$];
    logic [31:0] directed_s[$];
    int unsigned phase_pct[3];
    directed_h = '{32'h0000, 32'h8000, 32'h0001, 32'h83FF, 32'h0200, 32'h7C00,
                   32'hFC00, 32'h7E01, 32'hFFFF_7BFF, 32'h0400, 32'h3C00};
    directed_s = '{32'h0000_0000, 32'h8000_0001, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0000, 32'h7F80_0001, 32'h4780_0000, 32'h477F_FFFF,
                   32'h3880_0000, 32'h3800_0000, 32'h3300_0000, 32'h32FF_FFFF,
                   32'hFFFF_FFFF};
    phase_pct = '{21, 71, 0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_h[k]) send_word(MODE_H2S, directed_h[k]);
    foreach (directed_s[k]) send_word(MODE_S2H, directed_s[k]);
    release_start();
    wait_drained();
    for (int p = 0; p < 3; p++) begin
      idle_pct = phase_pct[p];
      for (int k = 0; k < 530; k++) begin
        if ($urandom_range(1)) send_word(MODE_S2H, random_single());
        else send_word(MODE_H2S, random_half());
        if (k == 200) begin
          release_start();
          wait_drained();
        end
      end
    end
    release_start();
    wait_drained();
    if (n_errors == 0 && sb.pending_words.size() == 0) begin
      $display("[half_single_float_convert] OK");
    end else begin
      if (sb.pending_words.size() != 0) report_mismatch("results missing at end");
      $display("[half_single_float_convert] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[half_single_float_convert] ERROR");
    $finish;
  end
endmodule

/* half_single_float_convert.f */
hw/rtl/hsfc_pkg.sv
hw/rtl/hsfc_core.sv
hw/rtl/half_single_float_convert.sv
test/tb_top.sv
